// ===== design/cpf_pkg.sv =====
// Shared types and constants for the command packet framer.
package cpf_pkg;

  // Header bytes and packet identifier.
  localparam logic [7:0] CPF_SYNC0 = 8'hEF;
  localparam logic [7:0] CPF_SYNC1 = 8'h01;
  localparam logic [7:0] CPF_IDENT = 8'h01;

  // Module address after reset.
  localparam logic [31:0] CPF_ADDR_RESET = 32'hFFFF_FFFF;

  // Largest payload count; larger counts saturate to it.
  localparam int CPF_MAX_PAYLOAD = 256;

  // Default depth of the queue between front and back.
  localparam int CPF_QUEUE_DEPTH = 4;

  // One classified payload byte as handed from front to back.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first;
    logic        last;
    logic [15:0] len;
    logic [15:0] sum;
  } cpf_cmd_t;

  // Status of the queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } cpf_queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_PAYLOAD,
    ST_SUM_HI,
    ST_SUM_LO
  } cpf_state_t;

endpackage

// ===== design/cpf_front.sv =====
// Front part: accepts payload bytes, tracks packet boundaries and the checksum.
module cpf_front
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // payload_byte[7:0], payload_count[16:8]
  input  cpf_queue_status_t q_status,
  output logic              push,
  output cpf_cmd_t          push_cmd
);

  logic        in_packet;
  logic [8:0]  bytes_left;
  logic [15:0] running_sum;

  logic [7:0]  pl_byte;
  logic [8:0]  pl_count;
  logic [8:0]  count_sat;
  logic [15:0] len;
  logic [8:0]  left_base;
  logic [8:0]  left_after;
  logic [15:0] sum_base;
  logic [15:0] sum_after;
  logic        is_last;

  assign pl_byte  = s_tdata[7:0];
  assign pl_count = s_tdata[16:8];

  always_comb begin
    if (pl_count == 9'd0) begin
      count_sat = 9'd1;
    end else if (32'(pl_count) > 32'(CPF_MAX_PAYLOAD)) begin
      count_sat = 9'(CPF_MAX_PAYLOAD);
    end else begin
      count_sat = pl_count;
    end
  end

  assign len = 16'(count_sat) + 16'd2;

  always_comb begin
    if (in_packet) begin
      left_base = bytes_left;
      sum_base  = running_sum;
    end else begin
      left_base = count_sat;
      sum_base  = 16'(CPF_IDENT) + 16'(len[15:8]) + 16'(len[7:0]);
    end
  end

  assign sum_after  = sum_base + 16'(pl_byte);
  assign left_after = (left_base != 9'd0) ? left_base - 9'd1 : 9'd0;
  assign is_last    = (left_after == 9'd0);

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_cmd.payload_byte = pl_byte;
    push_cmd.first        = !in_packet;
    push_cmd.last         = is_last;
    push_cmd.len          = len;
    push_cmd.sum          = sum_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet   <= 1'b0;
      bytes_left  <= 9'd0;
      running_sum <= 16'd0;
    end else if (push) begin
      in_packet   <= !is_last;
      bytes_left  <= left_after;
      running_sum <= is_last ? 16'd0 : sum_after;
    end
  end

endmodule

// ===== design/cpf_queue.sv =====
// Short queue of classified items between the front and back parts.
module cpf_queue
  import cpf_pkg::*;
#(
  parameter int DEPTH = CPF_QUEUE_DEPTH
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cpf_cmd_t          push_cmd,
  input  logic              pop,
  output cpf_cmd_t          head,
  output cpf_queue_status_t status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cpf_cmd_t          entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a write");
`endif

endmodule

// ===== design/cpf_back.sv =====
// Back part: sequences header, payload and checksum bytes into the output register.
module cpf_back
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       module_address,
  input  cpf_cmd_t          head,
  input  cpf_queue_status_t q_status,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // tx_byte[7:0]
  output logic              m_tlast
);

  localparam logic [3:0] HdrSync0  = 4'd0;
  localparam logic [3:0] HdrSync1  = 4'd1;
  localparam logic [3:0] HdrAddr3  = 4'd2;
  localparam logic [3:0] HdrAddr2  = 4'd3;
  localparam logic [3:0] HdrAddr1  = 4'd4;
  localparam logic [3:0] HdrAddr0  = 4'd5;
  localparam logic [3:0] HdrIdent  = 4'd6;
  localparam logic [3:0] HdrLenHi  = 4'd7;
  localparam logic [3:0] HdrLenLo  = 4'd8;

  cpf_state_t  state;
  cpf_state_t  state_next;
  logic [3:0]  hdr_idx;
  logic [3:0]  hdr_idx_next;
  cpf_cmd_t    cur;
  logic        advance;
  logic        load;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic [7:0]  hdr_byte;

  // The output register moves on when it is empty or being taken.
  assign advance = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    hdr_idx_next = hdr_idx;
    load         = 1'b0;
    case (state)
      ST_IDLE: begin
        load = !q_status.empty;
      end
      ST_HEADER: begin
        if (advance) begin
          if (hdr_idx == HdrLenLo) begin
            state_next = ST_PAYLOAD;
          end else begin
            hdr_idx_next = hdr_idx + 4'd1;
          end
        end
      end
      ST_PAYLOAD: begin
        if (advance) begin
          if (cur.last) begin
            state_next = ST_SUM_HI;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_SUM_HI: begin
        if (advance) begin
          state_next = ST_SUM_LO;
        end
      end
      ST_SUM_LO: begin
        load = advance;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Finishing one item picks up the next one in the same cycle.
    if (load) begin
      hdr_idx_next = HdrSync0;
      if (q_status.empty) begin
        state_next = ST_IDLE;
      end else if (head.first) begin
        state_next = ST_HEADER;
      end else begin
        state_next = ST_PAYLOAD;
      end
    end
  end

  assign pop = load && !q_status.empty;

  always_comb begin
    case (hdr_idx)
      HdrSync0: hdr_byte = CPF_SYNC0;
      HdrSync1: hdr_byte = CPF_SYNC1;
      HdrAddr3: hdr_byte = module_address[31:24];
      HdrAddr2: hdr_byte = module_address[23:16];
      HdrAddr1: hdr_byte = module_address[15:8];
      HdrAddr0: hdr_byte = module_address[7:0];
      HdrIdent: hdr_byte = CPF_IDENT;
      HdrLenHi: hdr_byte = cur.len[15:8];
      HdrLenLo: hdr_byte = cur.len[7:0];
      default:  hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_end  = 1'b0;
    case (state)
      ST_IDLE: begin
        emit = 1'b0;
      end
      ST_HEADER: begin
        emit      = 1'b1;
        emit_byte = hdr_byte;
      end
      ST_PAYLOAD: begin
        emit      = 1'b1;
        emit_byte = cur.payload_byte;
      end
      ST_SUM_HI: begin
        emit      = 1'b1;
        emit_byte = cur.sum[15:8];
      end
      ST_SUM_LO: begin
        emit      = 1'b1;
        emit_byte = cur.sum[7:0];
        emit_end  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hdr_idx  <= HdrSync0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      hdr_idx <= hdr_idx_next;
      if (advance) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_end;
    end
  end

endmodule

// ===== design/command_packet_framer_core.sv =====
// Top level of the command packet framer: front, queue, back and address register.
//
// Each accepted item is one payload byte. The first byte of a packet produces
// ten output items (two sync bytes, four address bytes, identifier, two length
// bytes and the byte itself), later bytes produce one, and the last byte adds
// two checksum bytes, the final one flagged with tlast. The back sequencer
// emits one output item per cycle through its output register while m_tready
// does not hold it off, so a packet of N payload bytes makes N + 11 output items.
// The front takes one input item per cycle while the queue (QUEUE_DEPTH entries)
// has room, so a packet's header and checksum time is absorbed by the queue and
// input backpressure. From idle, an accepted item goes via the queue, the back
// state and output registers. The module address is sampled when each header is sent.
module command_packet_framer_core
  import cpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = CPF_QUEUE_DEPTH
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,   // module_address[31:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,     // payload_byte[7:0], payload_count[16:8], zero[23:17]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // tx_byte[7:0]
  output logic        m_tlast      // packet_end
);

  logic [31:0]       module_address;
  logic              push;
  cpf_cmd_t          push_cmd;
  logic              pop;
  cpf_cmd_t          head;
  cpf_queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address <= CPF_ADDR_RESET;
    end else if (cfg_we) begin
      module_address <= cfg_wdata;
    end
  end

  cpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  cpf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .module_address (module_address),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule
